// File: design/swlm_pkg.sv
// Shared types, constants and SHA-256 helper functions for the word matcher.
package swlm_pkg;

    // Kind of work the back end is asked to do
    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_FINISH = 2'd1
    } op_t;

    // One queued command from the front end to the hash engine
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [7:0] hlen;
    } cmd_t;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: design/swlm_front.sv
// Front end: classifies incoming items into hash commands, tracks word length.
module swlm_front #(
    parameter int unsigned MAX_WORD = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                in_bvalid,
    input  logic                in_last,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output swlm_pkg::cmd_t      cmd
);
    // A single item can produce up to three commands: finish, byte, finish
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BYTE  = 4'b0010,
        ST_FIN   = 4'b0100,
        ST_CUT   = 4'b1000
    } fst_t;

    fst_t       st_reg, st_next;
    logic [7:0] bytes_reg, bytes_next;
    logic [7:0] hlen_reg, hlen_next;
    logic       zero_reg, zero_next;
    logic [7:0] data_reg, data_next;
    logic       hash_reg, hash_next;
    logic       last_reg, last_next;

    assign in_ready = (st_reg == ST_IDLE);

    always_comb begin
        st_next    = st_reg;
        bytes_next = bytes_reg;
        hlen_next  = hlen_reg;
        zero_next  = zero_reg;
        data_next  = data_reg;
        hash_next  = hash_reg;
        last_next  = last_reg;
        cmd_valid  = 1'b0;
        cmd        = '{op: swlm_pkg::OP_BYTE, data: data_reg, hlen: hlen_reg};
        unique case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    data_next = in_data;
                    last_next = in_last;
                    if (in_bvalid) begin
                        // Overflow closes the held word first
                        if (bytes_reg >= 8'(MAX_WORD)) begin
                            st_next = ST_CUT;
                        end else begin
                            hash_next = !zero_reg && (in_data != 8'd0);
                            st_next   = ST_BYTE;
                        end
                    end else if (in_last) begin
                        st_next = ST_FIN;
                    end
                end
            end
            ST_CUT: begin
                // Close the held word, then start the next one with the held byte
                cmd_valid = 1'b1;
                cmd.op    = swlm_pkg::OP_FINISH;
                cmd.hlen  = hlen_reg;
                if (cmd_ready) begin
                    bytes_next = 8'd0;
                    hlen_next  = 8'd0;
                    zero_next  = 1'b0;
                    hash_next  = (data_reg != 8'd0);
                    st_next    = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (hash_reg) begin
                    cmd_valid = 1'b1;
                    cmd.op    = swlm_pkg::OP_BYTE;
                end
                if (!hash_reg || cmd_ready) begin
                    bytes_next = bytes_reg + 8'd1;
                    if (hash_reg) hlen_next = hlen_reg + 8'd1;
                    else if (data_reg == 8'd0) zero_next = 1'b1;
                    st_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                cmd_valid = 1'b1;
                cmd.op    = swlm_pkg::OP_FINISH;
                cmd.hlen  = hlen_reg;
                if (cmd_ready) begin
                    bytes_next = 8'd0;
                    hlen_next  = 8'd0;
                    zero_next  = 1'b0;
                    st_next    = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Hold word tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            bytes_reg <= 8'd0;
            hlen_reg  <= 8'd0;
            zero_reg  <= 1'b0;
        end else begin
            st_reg    <= st_next;
            bytes_reg <= bytes_next;
            hlen_reg  <= hlen_next;
            zero_reg  <= zero_next;
        end
        data_reg <= data_next;
        hash_reg <= hash_next;
        last_reg <= last_next;
    end
endmodule

// File: design/swlm_fifo.sv
// Short command queue between front end and hash engine.
module swlm_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  swlm_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output swlm_pkg::cmd_t rd_cmd
);
    swlm_pkg::cmd_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic push, pop;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_cmd   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
        if (push) mem_reg[wp_reg] <= wr_cmd;
    end
endmodule

// File: design/swlm_engine.sv
// Hash engine: block packing, padding, 64-round compression, digest compare.
module swlm_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  swlm_pkg::cmd_t cmd,
    input  logic [255:0]   target,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [40:0]    res_data
);
    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_COMP = 5'b00010,
        E_PAD  = 5'b00100,
        E_ADD  = 5'b01000,
        E_OUT  = 5'b10000
    } est_t;

    est_t  st_reg;
    swlm_pkg::word_t h_reg [8];
    swlm_pkg::word_t v_reg [8];
    swlm_pkg::word_t w_reg [16];
    logic [5:0] fill_reg;
    logic [5:0] rnd_reg;
    logic       fin_reg;    // compression belongs to word finish
    logic       padlen_reg; // length bytes still to place after padding
    logic [7:0] hlen_reg;
    logic [31:0] wnum_reg;
    logic        oval_reg;
    logic [40:0] odata_reg;

    swlm_pkg::word_t s0, s1, wnew, e1, ch, t1, a0, mj;
    logic [255:0] dig;

    // Message schedule and round function on the window
    always_comb begin
        s0 = swlm_pkg::rotr(w_reg[1], 7) ^ swlm_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = swlm_pkg::rotr(w_reg[14], 17) ^ swlm_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        e1 = swlm_pkg::rotr(v_reg[4], 6) ^ swlm_pkg::rotr(v_reg[4], 11)
           ^ swlm_pkg::rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + e1 + ch + swlm_pkg::RK[rnd_reg] + w_reg[0];
        a0 = swlm_pkg::rotr(v_reg[0], 2) ^ swlm_pkg::rotr(v_reg[0], 13)
           ^ swlm_pkg::rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = h_reg[i];
    end

    assign cmd_ready = (st_reg == E_IDLE);
    assign res_valid = oval_reg;
    assign res_data  = odata_reg;

    // Place a byte or the finish marker into the block, pad, compress when full and emit the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= E_IDLE;
            fill_reg <= 6'd0;
            oval_reg <= 1'b0;
            wnum_reg <= 32'd0;
            for (int i = 0; i < 8; i++) h_reg[i] <= swlm_pkg::INIT_HASH[i];
        end else begin
            if (oval_reg && res_ready) oval_reg <= 1'b0;
            unique case (st_reg)
                E_IDLE: begin
                    if (cmd_valid) begin
                        fin_reg <= (cmd.op == swlm_pkg::OP_FINISH);
                        hlen_reg <= cmd.hlen;
                        if (cmd.op == swlm_pkg::OP_FINISH) begin
                            w_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= 8'h80;
                            if (fill_reg[1:0] == 2'd0)
                                w_reg[fill_reg[5:2]][23:0] <= 24'd0;
                            fill_reg <= fill_reg + 6'd1;
                            padlen_reg <= 1'b1;
                            // Marker filled the block: compress it before padding
                            if (fill_reg == 6'd63) begin
                                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                                rnd_reg <= 6'd0;
                                st_reg <= E_COMP;
                            end else begin
                                st_reg <= E_PAD;
                            end
                        end else begin
                            if (fill_reg[1:0] == 2'd0)
                                w_reg[fill_reg[5:2]][23:0] <= 24'd0;
                            w_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= cmd.data;
                            fill_reg <= fill_reg + 6'd1;
                            if (fill_reg == 6'd63) begin
                                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                                rnd_reg <= 6'd0;
                                st_reg <= E_COMP;
                            end
                        end
                    end
                end
                E_PAD: begin
                    // Zero the rest of a word, then whole words, then place the bit length
                    if (fill_reg[1:0] != 2'd0) begin
                        fill_reg <= {fill_reg[5:2] + 4'd1, 2'd0};
                        if (fill_reg[5:2] == 4'd15) begin
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                            rnd_reg <= 6'd0;
                            st_reg <= E_COMP;
                        end
                    end else if (padlen_reg && fill_reg == 6'd56) begin
                        w_reg[14] <= 32'd0;
                        w_reg[15] <= {21'd0, hlen_reg, 3'd0};
                        padlen_reg <= 1'b0;
                        fill_reg <= 6'd0;
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        rnd_reg <= 6'd0;
                        st_reg <= E_COMP;
                    end else begin
                        w_reg[fill_reg[5:2]] <= 32'd0;
                        fill_reg <= fill_reg + 6'd4;
                        if (fill_reg == 6'd60) begin
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                            rnd_reg <= 6'd0;
                            st_reg <= E_COMP;
                        end
                    end
                end
                E_COMP: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + a0 + mj;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) st_reg <= E_ADD;
                end
                E_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    fill_reg <= 6'd0;
                    if (fin_reg && padlen_reg) st_reg <= E_PAD;
                    else if (fin_reg) st_reg <= E_OUT;
                    else st_reg <= E_IDLE;
                end
                E_OUT: begin
                    if (!oval_reg) begin
                        oval_reg <= 1'b1;
                        odata_reg <= {hlen_reg, wnum_reg, dig == target};
                        if (wnum_reg != 32'hFFFFFFFF) wnum_reg <= wnum_reg + 32'd1;
                        for (int i = 0; i < 8; i++) h_reg[i] <= swlm_pkg::INIT_HASH[i];
                        st_reg <= E_IDLE;
                    end
                end
                default: st_reg <= E_IDLE;
            endcase
        end
    end
endmodule

// File: design/sha256_word_list_match.sv
// Top level: a word of bytes in, one item per word end with SHA-256 match result out.
// The front end takes a new input item only once it has issued the commands for the
// last one (closing an overlong word first), queueing one command per hashed byte;
// the engine packs each byte into the block, and every 64 hashed bytes run one 64-round
// compression on the single round unit. Each word end adds one or two padding
// compressions. A result waits in an output register while the next items are queued.
// Target digest is written through cfg_wr_en/cfg_index/cfg_data, registers 0..3
// holding digest bytes 0..7 .. 24..31.
module sha256_word_list_match #(
    parameter int unsigned MAX_WORD = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] word_number, [39:32] hashed_length
    output logic        m_tuser,   // match_found
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [63:0] tgt_reg [4];
    logic [255:0] target;
    logic fv, fr, ev, er;
    swlm_pkg::cmd_t fc, ec;
    logic [40:0] res;

    // Hold target registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) tgt_reg[i] <= 64'd0;
        end else if (cfg_wr_en) begin
            tgt_reg[cfg_index] <= cfg_data;
        end
    end
    assign target = {tgt_reg[0], tgt_reg[1], tgt_reg[2], tgt_reg[3]};

    swlm_front #(.MAX_WORD(MAX_WORD)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .in_bvalid(s_tuser), .in_last(s_tlast),
        .cmd_valid(fv), .cmd_ready(fr), .cmd(fc)
    );
    swlm_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fv), .wr_ready(fr), .wr_cmd(fc),
        .rd_valid(ev), .rd_ready(er), .rd_cmd(ec)
    );
    swlm_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(ev), .cmd_ready(er), .cmd(ec), .target(target),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
    );
    assign m_tuser = res[0];
    assign m_tdata = res[40:1];
endmodule

// File: design/swlm_checker.sv
// Port-level checker for the word matcher, bound to the top level.
module swlm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("result fields unknown");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind sha256_word_list_match swlm_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
